@@ src/stsc_pkg.sv @@
// Shared types, token codes and character helpers for the source token scanner.
`default_nettype none

package stsc_pkg;

    // Item kinds on the input channel.
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    // Token kind codes.
    localparam logic [4:0] KIND_LPAREN        = 5'd0;
    localparam logic [4:0] KIND_RPAREN        = 5'd1;
    localparam logic [4:0] KIND_LBRACE        = 5'd2;
    localparam logic [4:0] KIND_RBRACE        = 5'd3;
    localparam logic [4:0] KIND_COMMA         = 5'd4;
    localparam logic [4:0] KIND_DOT           = 5'd5;
    localparam logic [4:0] KIND_MINUS         = 5'd6;
    localparam logic [4:0] KIND_PLUS          = 5'd7;
    localparam logic [4:0] KIND_SEMICOLON     = 5'd8;
    localparam logic [4:0] KIND_STAR          = 5'd9;
    localparam logic [4:0] KIND_BANG          = 5'd10;
    localparam logic [4:0] KIND_BANG_EQUAL    = 5'd11;
    localparam logic [4:0] KIND_EQUAL         = 5'd12;
    localparam logic [4:0] KIND_EQUAL_EQUAL   = 5'd13;
    localparam logic [4:0] KIND_LESS          = 5'd14;
    localparam logic [4:0] KIND_LESS_EQUAL    = 5'd15;
    localparam logic [4:0] KIND_GREATER       = 5'd16;
    localparam logic [4:0] KIND_GREATER_EQUAL = 5'd17;
    localparam logic [4:0] KIND_SLASH         = 5'd18;
    localparam logic [4:0] KIND_IDENT         = 5'd19;
    localparam logic [4:0] KIND_NUMBER        = 5'd20;
    localparam logic [4:0] KIND_KW_INT        = 5'd21;
    localparam logic [4:0] KIND_KW_IF         = 5'd22;
    localparam logic [4:0] KIND_KW_ELSE       = 5'd23;
    localparam logic [4:0] KIND_KW_WHILE      = 5'd24;
    localparam logic [4:0] KIND_KW_PRINT      = 5'd25;
    localparam logic [4:0] KIND_KW_INPUT      = 5'd26;
    localparam logic [4:0] KIND_ERROR         = 5'd27;
    localparam logic [4:0] KIND_EOF           = 5'd28;

    // Keyword spellings, first character most significant.
    localparam logic [39:0] WORD_INT   = 40'h00_0069_6E74;
    localparam logic [39:0] WORD_IF    = 40'h00_0000_6966;
    localparam logic [39:0] WORD_ELSE  = 40'h00_656C_7365;
    localparam logic [39:0] WORD_WHILE = 40'h77_6869_6C65;
    localparam logic [39:0] WORD_PRINT = 40'h70_7269_6E74;
    localparam logic [39:0] WORD_INPUT = 40'h69_6E70_7574;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Result queue depth; room for two results is needed to take an item.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_BANG    = 9'b000000010,
        MODE_EQUAL   = 9'b000000100,
        MODE_LESS    = 9'b000001000,
        MODE_GREATER = 9'b000010000,
        MODE_SLASH   = 9'b000100000,
        MODE_COMMENT = 9'b001000000,
        MODE_IDENT   = 9'b010000000,
        MODE_NUMBER  = 9'b100000000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [39:0] keyword_chars;
        logic        too_long;
    } t_scan_state;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] text_length;
        logic [15:0] line_number;
        logic [7:0]  error_byte;
        logic        position_overflow;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } t_punct;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
            || (b == CH_UNDERSCORE);
    endfunction

    function automatic t_punct punct_lookup(input logic [7:0] b);
        t_punct p;
        p.hit  = 1'b1;
        p.kind = KIND_LPAREN;
        case (b)
            8'h28:   p.kind = KIND_LPAREN;
            8'h29:   p.kind = KIND_RPAREN;
            8'h7B:   p.kind = KIND_LBRACE;
            8'h7D:   p.kind = KIND_RBRACE;
            8'h2C:   p.kind = KIND_COMMA;
            8'h2E:   p.kind = KIND_DOT;
            8'h2D:   p.kind = KIND_MINUS;
            8'h2B:   p.kind = KIND_PLUS;
            8'h3B:   p.kind = KIND_SEMICOLON;
            8'h2A:   p.kind = KIND_STAR;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [39:0] chars,
                                              input logic too_long);
        logic [4:0] k;
        k = KIND_IDENT;
        if (!too_long) begin
            if (chars == WORD_INT)        k = KIND_KW_INT;
            else if (chars == WORD_IF)    k = KIND_KW_IF;
            else if (chars == WORD_ELSE)  k = KIND_KW_ELSE;
            else if (chars == WORD_WHILE) k = KIND_KW_WHILE;
            else if (chars == WORD_PRINT) k = KIND_KW_PRINT;
            else if (chars == WORD_INPUT) k = KIND_KW_INPUT;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ src/stsc_step.sv @@
// Combinational scan step: one word against the scanner state, next state and up to two tokens.
`default_nettype none

module stsc_step #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                     i_kind,
    input  wire logic [7:0]               i_byte_value,
    input  wire stsc_pkg::t_scan_state    i_scan,
    input  wire logic [POSITION_BITS-1:0] i_token_start,
    input  wire logic [POSITION_BITS-1:0] i_byte_position,
    input  wire logic [POSITION_BITS-1:0] i_line_count,
    output stsc_pkg::t_scan_state         o_scan,
    output logic [POSITION_BITS-1:0]      o_token_start,
    output logic [POSITION_BITS-1:0]      o_byte_position,
    output logic [POSITION_BITS-1:0]      o_line_count,
    output stsc_pkg::t_result [1:0]       o_results,
    output logic [1:0]                    o_result_count
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Clamp a position-wide value to the 16-bit result field; top bit flags a clamp.
    function automatic logic [16:0] clamp_field(input logic [POSITION_BITS-1:0] v);
        logic over;
        over = (v > POSITION_BITS'(17'h0FFFF));
        return {over, (over ? 16'hFFFF : 16'(v))};
    endfunction

    function automatic stsc_pkg::t_result make_result(
        input logic [4:0]               kind,
        input logic [POSITION_BITS-1:0] start,
        input logic [POSITION_BITS-1:0] len,
        input logic [POSITION_BITS-1:0] line,
        input logic [7:0]               err,
        input logic                     ovf_base
    );
        stsc_pkg::t_result r;
        logic [16:0] c_start;
        logic [16:0] c_len;
        logic [16:0] c_line;
        c_start = clamp_field(start);
        c_len   = clamp_field(len);
        c_line  = clamp_field(line);
        r.token_kind        = kind;
        r.start_offset      = c_start[15:0];
        r.text_length       = c_len[15:0];
        r.line_number       = c_line[15:0];
        r.error_byte        = err;
        r.position_overflow = ovf_base | c_start[16] | c_len[16] | c_line[16];
        r.last_of_run       = 1'b0;
        return r;
    endfunction

    logic                     is_end;
    logic [7:0]               b;
    logic [POSITION_BITS-1:0] pos_used;
    logic [POSITION_BITS-1:0] flush_len;
    logic                     ovf_base;
    logic                     do_flush;
    logic                     do_dispatch;
    logic                     f_valid;
    logic [4:0]               f_kind;
    logic [POSITION_BITS-1:0] f_start;
    logic [POSITION_BITS-1:0] f_len;
    logic                     d_valid;
    logic [4:0]               d_kind;
    logic [POSITION_BITS-1:0] d_start;
    logic [POSITION_BITS-1:0] d_len;
    logic [7:0]               d_err;
    stsc_pkg::t_punct         punct;
    stsc_pkg::t_result        f_res;
    stsc_pkg::t_result        d_res;

    assign is_end = (i_kind == stsc_pkg::ITEM_END);
    assign b      = i_byte_value;
    assign punct  = stsc_pkg::punct_lookup(b);

    // Byte count that the emitted tokens see: bumped for a byte, as is for end of source.
    assign pos_used = is_end ? i_byte_position
                    : ((i_byte_position < POS_MAX) ? (i_byte_position + POS_ONE)
                                                   : i_byte_position);
    assign flush_len = (i_byte_position >= i_token_start) ? (i_byte_position - i_token_start)
                                                          : '0;
    assign ovf_base = (pos_used >= POS_MAX) || (i_line_count >= POS_MAX);

    // Mode transitions and the token that the byte ends or pairs into.
    always_comb begin
        o_scan          = i_scan;
        o_token_start   = i_token_start;
        o_byte_position = pos_used;
        o_line_count    = i_line_count;
        do_flush        = 1'b0;
        do_dispatch     = 1'b0;
        f_valid         = 1'b0;
        f_kind          = stsc_pkg::KIND_BANG;
        f_start         = i_token_start;
        f_len           = POS_ONE;
        d_valid         = 1'b0;
        d_kind          = stsc_pkg::KIND_EOF;
        d_start         = i_byte_position;
        d_len           = '0;
        d_err           = 8'h00;

        if (is_end) begin
            do_flush = 1'b1;
            d_valid  = 1'b1;
        end else begin
            unique case (i_scan.mode)
                stsc_pkg::MODE_BANG, stsc_pkg::MODE_EQUAL,
                stsc_pkg::MODE_LESS, stsc_pkg::MODE_GREATER: begin
                    if (b == stsc_pkg::CH_EQUAL) begin
                        f_valid     = 1'b1;
                        f_len       = POSITION_BITS'(2);
                        o_scan.mode = stsc_pkg::MODE_IDLE;
                        unique case (i_scan.mode)
                            stsc_pkg::MODE_BANG:  f_kind = stsc_pkg::KIND_BANG_EQUAL;
                            stsc_pkg::MODE_EQUAL: f_kind = stsc_pkg::KIND_EQUAL_EQUAL;
                            stsc_pkg::MODE_LESS:  f_kind = stsc_pkg::KIND_LESS_EQUAL;
                            default:              f_kind = stsc_pkg::KIND_GREATER_EQUAL;
                        endcase
                    end else begin
                        do_flush    = 1'b1;
                        do_dispatch = 1'b1;
                    end
                end
                stsc_pkg::MODE_SLASH: begin
                    if (b == stsc_pkg::CH_SLASH) begin
                        o_scan.mode = stsc_pkg::MODE_COMMENT;
                    end else begin
                        do_flush    = 1'b1;
                        do_dispatch = 1'b1;
                    end
                end
                stsc_pkg::MODE_COMMENT: begin
                    if (b == stsc_pkg::CH_NEWLINE) begin
                        do_dispatch = 1'b1;
                    end
                end
                stsc_pkg::MODE_IDENT: begin
                    if (stsc_pkg::is_alpha(b) || stsc_pkg::is_digit(b)) begin
                        if (i_scan.keyword_chars[39:32] != 8'h00) begin
                            o_scan.too_long = 1'b1;
                        end else begin
                            o_scan.keyword_chars = {i_scan.keyword_chars[31:0], b};
                        end
                    end else begin
                        do_flush    = 1'b1;
                        do_dispatch = 1'b1;
                    end
                end
                stsc_pkg::MODE_NUMBER: begin
                    if (!stsc_pkg::is_digit(b)) begin
                        do_flush    = 1'b1;
                        do_dispatch = 1'b1;
                    end
                end
                default: begin
                    do_flush    = 1'b1;
                    do_dispatch = 1'b1;
                end
            endcase
        end

        // Close whatever token is open; it ends just before the current byte.
        if (do_flush) begin
            o_scan.mode = stsc_pkg::MODE_IDLE;
            f_valid     = 1'b1;
            f_len       = POS_ONE;
            unique case (i_scan.mode)
                stsc_pkg::MODE_BANG:    f_kind = stsc_pkg::KIND_BANG;
                stsc_pkg::MODE_EQUAL:   f_kind = stsc_pkg::KIND_EQUAL;
                stsc_pkg::MODE_LESS:    f_kind = stsc_pkg::KIND_LESS;
                stsc_pkg::MODE_GREATER: f_kind = stsc_pkg::KIND_GREATER;
                stsc_pkg::MODE_SLASH:   f_kind = stsc_pkg::KIND_SLASH;
                stsc_pkg::MODE_IDENT: begin
                    f_kind = stsc_pkg::ident_kind(i_scan.keyword_chars, i_scan.too_long);
                    f_len  = flush_len;
                end
                stsc_pkg::MODE_NUMBER: begin
                    f_kind = stsc_pkg::KIND_NUMBER;
                    f_len  = flush_len;
                end
                default: f_valid = 1'b0;
            endcase
        end

        // Start of a new token from the idle mode.
        if (do_dispatch) begin
            o_scan.mode   = stsc_pkg::MODE_IDLE;
            o_token_start = i_byte_position;
            d_start       = i_byte_position;
            d_len         = POS_ONE;
            if (punct.hit) begin
                d_valid = 1'b1;
                d_kind  = punct.kind;
            end else begin
                case (b)
                    stsc_pkg::CH_BANG:    o_scan.mode = stsc_pkg::MODE_BANG;
                    stsc_pkg::CH_EQUAL:   o_scan.mode = stsc_pkg::MODE_EQUAL;
                    stsc_pkg::CH_LESS:    o_scan.mode = stsc_pkg::MODE_LESS;
                    stsc_pkg::CH_GREATER: o_scan.mode = stsc_pkg::MODE_GREATER;
                    stsc_pkg::CH_SLASH:   o_scan.mode = stsc_pkg::MODE_SLASH;
                    stsc_pkg::CH_SPACE, stsc_pkg::CH_CR, stsc_pkg::CH_TAB: begin
                    end
                    stsc_pkg::CH_NEWLINE: begin
                        if (i_line_count < POS_MAX) begin
                            o_line_count = i_line_count + POS_ONE;
                        end
                    end
                    default: begin
                        if (stsc_pkg::is_digit(b)) begin
                            o_scan.mode = stsc_pkg::MODE_NUMBER;
                        end else if (stsc_pkg::is_alpha(b)) begin
                            o_scan.mode          = stsc_pkg::MODE_IDENT;
                            o_scan.keyword_chars = {32'h0, b};
                            o_scan.too_long      = 1'b0;
                        end else begin
                            d_valid = 1'b1;
                            d_kind  = stsc_pkg::KIND_ERROR;
                            d_err   = b;
                        end
                    end
                endcase
            end
        end

        // End of source returns everything to the reset state.
        if (is_end) begin
            o_scan.mode          = stsc_pkg::MODE_IDLE;
            o_scan.keyword_chars = 40'h0;
            o_scan.too_long      = 1'b0;
            o_token_start        = '0;
            o_byte_position      = '0;
            o_line_count         = POS_ONE;
        end
    end

    assign f_res = make_result(f_kind, f_start, f_len, i_line_count, 8'h00, ovf_base);
    assign d_res = make_result(d_kind, d_start, d_len, i_line_count, d_err, ovf_base);

    // Pack the tokens in order, the closed token first; flag the final one.
    always_comb begin
        o_results      = '0;
        o_result_count = 2'd0;
        if (f_valid && d_valid) begin
            o_results[0]             = f_res;
            o_results[1]             = d_res;
            o_results[1].last_of_run = 1'b1;
            o_result_count           = 2'd2;
        end else if (f_valid) begin
            o_results[0]             = f_res;
            o_results[0].last_of_run = 1'b1;
            o_result_count           = 2'd1;
        end else if (d_valid) begin
            o_results[0]             = d_res;
            o_results[0].last_of_run = 1'b1;
            o_result_count           = 2'd1;
        end
    end

endmodule

`default_nettype wire

@@ src/stsc_result_queue.sv @@
// Small result queue that takes up to two tokens per cycle and hands out one.
`default_nettype none

module stsc_result_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [1:0]              i_push_count,
    input  wire stsc_pkg::t_result [1:0] i_push_data,
    output logic                         o_room_for_two,
    output logic                         o_valid,
    output stsc_pkg::t_result            o_data,
    input  wire logic                    i_pop
);

    localparam int PB = stsc_pkg::QUEUE_PTR_BITS;
    localparam int CB = stsc_pkg::QUEUE_CNT_BITS;

    stsc_pkg::t_result r_entries [stsc_pkg::QUEUE_DEPTH];
    logic [PB-1:0]     r_wr_ptr;
    logic [PB-1:0]     r_rd_ptr;
    logic [CB-1:0]     r_count;
    logic [PB-1:0]     n_wr_ptr;
    logic [PB-1:0]     n_rd_ptr;
    logic [CB-1:0]     n_count;
    logic              pop;

    assign o_valid        = (r_count != '0);
    assign o_data         = r_entries[r_rd_ptr];
    assign o_room_for_two = (r_count <= CB'(stsc_pkg::QUEUE_DEPTH - 2));
    assign pop            = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PB'(i_push_count);
        n_rd_ptr = r_rd_ptr + PB'(pop);
        n_count  = r_count + CB'(i_push_count) - CB'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_entries[r_wr_ptr] <= i_push_data[0];
        end
        if (i_push_count == 2'd2) begin
            r_entries[r_wr_ptr + PB'(1)] <= i_push_data[1];
        end
    end

endmodule

`default_nettype wire

@@ src/source_token_scanner_core.sv @@
// Top level of the source token scanner: scanner state, scan step and result queue.
`default_nettype none

// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_ready    i_kind, i_byte_value
// result    out        o_out_valid / i_out_ready  o_token_kind .. o_last_of_run
//
// One word is taken per cycle while o_in_ready is high; its tokens enter the result queue
// at the accepting edge, and with the queue empty the first is on the output next cycle.
// A word is taken only while the four-entry queue holds at most two tokens. The output
// drains one token per cycle while i_out_ready is high, so a word that yields two tokens
// leaves one behind, and a second such word before the queue drains stalls the input.
// Reset (synchronous, active low) empties the queue and idles the scanner at line one.
module source_token_scanner_core #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_byte_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_start_offset,
    output logic [15:0]      o_text_length,
    output logic [15:0]      o_line_number,
    output logic [7:0]       o_error_byte,
    output logic             o_position_overflow,
    output logic             o_last_of_run
);

    // Scanner state: mode, keyword capture, token start, byte count and line count.
    stsc_pkg::t_scan_state    r_scan;
    logic [POSITION_BITS-1:0] r_token_start;
    logic [POSITION_BITS-1:0] r_byte_position;
    logic [POSITION_BITS-1:0] r_line_count;

    stsc_pkg::t_scan_state    n_scan;
    logic [POSITION_BITS-1:0] n_token_start;
    logic [POSITION_BITS-1:0] n_byte_position;
    logic [POSITION_BITS-1:0] n_line_count;

    stsc_pkg::t_result [1:0]  step_results;
    logic [1:0]               step_count;
    logic [1:0]               push_count;
    logic                     in_accept;
    logic                     room_for_two;
    stsc_pkg::t_result        head;

    assign o_in_ready = room_for_two;
    assign in_accept  = i_in_valid && room_for_two;
    assign push_count = in_accept ? step_count : 2'd0;

    stsc_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_kind          (i_kind),
        .i_byte_value    (i_byte_value),
        .i_scan          (r_scan),
        .i_token_start   (r_token_start),
        .i_byte_position (r_byte_position),
        .i_line_count    (r_line_count),
        .o_scan          (n_scan),
        .o_token_start   (n_token_start),
        .o_byte_position (n_byte_position),
        .o_line_count    (n_line_count),
        .o_results       (step_results),
        .o_result_count  (step_count)
    );

    // The state advances only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.mode          <= stsc_pkg::MODE_IDLE;
            r_scan.keyword_chars <= 40'h0;
            r_scan.too_long      <= 1'b0;
            r_token_start        <= '0;
            r_byte_position      <= '0;
            r_line_count         <= POSITION_BITS'(1);
        end else if (in_accept) begin
            r_scan          <= n_scan;
            r_token_start   <= n_token_start;
            r_byte_position <= n_byte_position;
            r_line_count    <= n_line_count;
        end
    end

    // The queue decouples both sides: a finished token waits there while new words come in.
    stsc_result_queue u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push_count   (push_count),
        .i_push_data    (step_results),
        .o_room_for_two (room_for_two),
        .o_valid        (o_out_valid),
        .o_data         (head),
        .i_pop          (i_out_ready)
    );

    assign o_token_kind        = head.token_kind;
    assign o_start_offset      = head.start_offset;
    assign o_text_length       = head.text_length;
    assign o_line_number       = head.line_number;
    assign o_error_byte        = head.error_byte;
    assign o_position_overflow = head.position_overflow;
    assign o_last_of_run       = head.last_of_run;

endmodule

`default_nettype wire

@@ src/stsc_checker.sv @@
// Port-level checks for the source token scanner, bound to its top level.
`default_nettype none

module stsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_kind,
    input wire logic [7:0]  i_byte_value,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [4:0]  o_token_kind,
    input wire logic [15:0] o_start_offset,
    input wire logic [15:0] o_text_length,
    input wire logic [15:0] o_line_number,
    input wire logic [7:0]  o_error_byte,
    input wire logic        o_position_overflow,
    input wire logic        o_last_of_run
);

    // A waiting input word stays in place.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_kind)
            && $stable(i_byte_value))
        else $error("waiting input word changed");

    // A stalled token stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind)
            && $stable(o_start_offset) && $stable(o_text_length)
            && $stable(o_line_number) && $stable(o_error_byte)
            && $stable(o_position_overflow) && $stable(o_last_of_run))
        else $error("stalled token changed");

    // An end-of-source token has no text and closes its run.
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == stsc_pkg::KIND_EOF)
            |-> (o_text_length == 16'd0) && o_last_of_run)
        else $error("malformed eof token");

    // An error token covers one byte and closes its run; only error tokens carry a byte.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_token_kind == stsc_pkg::KIND_ERROR)
            ? ((o_text_length == 16'd1) && o_last_of_run)
            : (o_error_byte == 8'h00)))
        else $error("malformed error token");

    // Lines count from one.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_number != 16'd0))
        else $error("token on line zero");

endmodule

bind source_token_scanner_core stsc_checker u_stsc_checker (.*);

`default_nettype wire
